/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the PWM LED controller register block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent that must hold at the clock edge after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/pwmlc_pkg.sv */
// Package of types, codes and constants for the PWM LED controller register block.
package pwmlc_pkg;

	localparam int CHANNELS_DEF = 16;

	// Operation codes of an input transaction.
	localparam logic [1:0] OP_PTR  = 2'd0;
	localparam logic [1:0] OP_WR   = 2'd1;
	localparam logic [1:0] OP_RD   = 2'd2;
	localparam logic [1:0] OP_TICK = 2'd3;

	// Register map.
	localparam logic [7:0] ADDR_MODE1    = 8'h00;
	localparam logic [7:0] ADDR_MODE2    = 8'h01;
	localparam logic [7:0] ADDR_CH_BASE  = 8'h06;
	localparam logic [7:0] ADDR_ALL_BASE = 8'hFA;
	localparam logic [7:0] ADDR_ALL_LAST = 8'hFD;
	localparam logic [7:0] ADDR_PRESCALE = 8'hFE;

	// MODE1 and MODE2 bit positions.
	localparam int M1_RESTART = 7;
	localparam int M1_EXTCLK  = 6;
	localparam int M1_AUTOINC = 5;
	localparam int M1_SLEEP   = 4;
	localparam int M2_INVRT   = 4;

	// Bit 4 of ON_H is full-on, bit 4 of OFF_H is full-off.
	localparam int FLAG_FULL = 4;

	// Byte positions within a channel.
	localparam logic [1:0] BYTE_ON_L  = 2'd0;
	localparam logic [1:0] BYTE_ON_H  = 2'd1;
	localparam logic [1:0] BYTE_OFF_L = 2'd2;
	localparam logic [1:0] BYTE_OFF_H = 2'd3;

	localparam logic [7:0] MODE1_RST    = 8'h11;
	localparam logic [7:0] MODE2_RST    = 8'h04;
	localparam logic [7:0] PRESCALE_RST = 8'h1E;
	localparam logic [7:0] PRESCALE_MIN = 8'h03;
	localparam logic [7:0] OFF_H_RST    = 8'h10;
	localparam logic [7:0] HIGH_MASK    = 8'h1F;

	// Write request to one channel's byte registers.
	typedef struct packed {
		logic       en;
		logic [1:0] sel;
		logic [7:0] data;
	} chan_wr_t;

	// The high bytes keep only bits 4:0.
	function automatic logic [7:0] byte_mask(input logic [1:0] sel, input logic [7:0] d);
		byte_mask = sel[0] ? (d & HIGH_MASK) : d;
	endfunction

endpackage

/* hw/rtl/pwmlc_in_if.sv */
// Input channel of the PWM LED controller register block: one operation per transaction.
interface pwmlc_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] reg_address;
	logic [7:0] data_byte;

	modport source(output valid, output operation, output reg_address, output data_byte,
		input ready);
	modport sink(input valid, input operation, input reg_address, input data_byte,
		output ready);
endinterface

/* hw/rtl/pwmlc_out_if.sv */
// Result channel of the PWM LED controller register block: one result per operation.
interface pwmlc_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  read_data;
	logic [15:0] pwm_outputs;
	logic        period_start;

	modport source(output valid, output read_data, output pwm_outputs, output period_start,
		input ready);
	modport sink(input valid, input read_data, input pwm_outputs, input period_start,
		output ready);
endinterface

/* hw/rtl/pwmlc_chan.sv */
// One PWM channel: its ON and OFF byte registers and its output level comparison.
module pwmlc_chan (
	input  logic                clk,
	input  logic                arst_n,
	input  pwmlc_pkg::chan_wr_t wr,
	input  logic [11:0]         cnt_next,
	output logic [3:0][7:0]     bytes,
	output logic                level_next
);

	logic [3:0][7:0] bytes_q;
	logic [3:0][7:0] bytes_n;
	logic [11:0]     on_cnt;
	logic [11:0]     off_cnt;

	always_comb begin
		bytes_n = bytes_q;
		if (wr.en) begin
			bytes_n[wr.sel] = pwmlc_pkg::byte_mask(wr.sel, wr.data);
		end
	end

	// Only OFF_H comes out of reset non-zero, with full-off set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q <= {pwmlc_pkg::OFF_H_RST, 8'h00, 8'h00, 8'h00};
		end else begin
			bytes_q <= bytes_n;
		end
	end

	assign on_cnt  = {bytes_n[pwmlc_pkg::BYTE_ON_H][3:0], bytes_n[pwmlc_pkg::BYTE_ON_L]};
	assign off_cnt = {bytes_n[pwmlc_pkg::BYTE_OFF_H][3:0], bytes_n[pwmlc_pkg::BYTE_OFF_L]};

	// The level follows the state as it stands after the current transaction.
	// Full-off wins over full-on; when ON is past OFF the high phase wraps round.
	always_comb begin
		if (bytes_n[pwmlc_pkg::BYTE_OFF_H][pwmlc_pkg::FLAG_FULL]) begin
			level_next = 1'b0;
		end else if (bytes_n[pwmlc_pkg::BYTE_ON_H][pwmlc_pkg::FLAG_FULL]) begin
			level_next = 1'b1;
		end else if (on_cnt == off_cnt) begin
			level_next = 1'b0;
		end else if (on_cnt < off_cnt) begin
			level_next = (cnt_next >= on_cnt) && (cnt_next < off_cnt);
		end else begin
			level_next = (cnt_next >= on_cnt) || (cnt_next < off_cnt);
		end
	end

	assign bytes = bytes_q;

endmodule

/* hw/rtl/pwm_led_controller_registers_unit.sv */
// Top level of the PWM LED controller register block.
// Each input transaction is one operation (pointer load, byte write, byte read or oscillator
// tick) and gives exactly one result transaction carrying the read byte, the channel levels
// after the operation and the period-start flag. A transaction is held in an input register
// and is worked into the result register at the next clock edge at which that register is
// free or being emptied, from which its result is offered. One transaction is accepted in
// every cycle in which the input register is empty or moving on; input ready therefore
// follows result ready combinationally when both stages are full. The per-channel
// comparison of the ON and OFF counts against the PWM counter sits in the path into the
// result register.
`include "assert_macros.svh"

module pwm_led_controller_registers_unit #(
	parameter int CHANNELS = pwmlc_pkg::CHANNELS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	pwmlc_in_if.sink     item,
	pwmlc_out_if.source  result
);

	localparam int         CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [7:0] ADDR_CH_LAST = 8'(32'(pwmlc_pkg::ADDR_CH_BASE) + 4 * CHANNELS - 1);

	// Input register.
	logic       valid_s1;
	logic [1:0] op_s1;
	logic [7:0] addr_s1;
	logic [7:0] data_s1;

	// Architectural state.
	logic [7:0]  ptr_q;
	logic [7:0]  mode1_q;
	logic [7:0]  mode2_q;
	logic [7:0]  presc_q;
	logic [7:0]  pcnt_q;
	logic [11:0] cnt_q;

	logic [7:0]  ptr_n;
	logic [7:0]  mode1_n;
	logic [7:0]  mode2_n;
	logic [7:0]  presc_n;
	logic [7:0]  pcnt_n;
	logic [11:0] cnt_n;

	// Result register.
	logic        out_valid_q;
	logic [7:0]  rd_q;
	logic [15:0] pwm_q;
	logic        wrap_q;

	logic        proc;
	logic        in_ch;
	logic        in_all;
	logic [7:0]  ch_off;
	logic [CH_W-1:0] ch_sel;
	logic [1:0]  wr_sel;
	logic [7:0]  rd_n;
	logic        wrap_n;
	logic        any_active;
	logic        rst_bit;
	logic        ext_bit;
	logic [15:0] pwm_n;

	pwmlc_pkg::chan_wr_t      ch_wr [CHANNELS];
	logic [3:0][7:0]          ch_bytes [CHANNELS];
	logic [CHANNELS-1:0]      lev;
	logic [CHANNELS-1:0]      ch_active;

	assign proc       = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			op_s1   <= item.operation;
			addr_s1 <= item.reg_address;
			data_s1 <= item.data_byte;
		end
	end

	// Address decode of the current pointer.
	assign ch_off = ptr_q - pwmlc_pkg::ADDR_CH_BASE;
	assign ch_sel = ch_off[CH_W+1:2];
	assign in_ch  = (ptr_q >= pwmlc_pkg::ADDR_CH_BASE) && (ptr_q <= ADDR_CH_LAST);
	assign in_all = (ptr_q >= pwmlc_pkg::ADDR_ALL_BASE) && (ptr_q <= pwmlc_pkg::ADDR_ALL_LAST);
	// The all-channel block starts at an address whose low bits are two.
	assign wr_sel = in_all ? (ptr_q[1:0] - pwmlc_pkg::ADDR_ALL_BASE[1:0]) : ch_off[1:0];

	for (genvar n = 0; n < CHANNELS; n++) begin : g_chan
		assign ch_wr[n].en   = proc && (op_s1 == pwmlc_pkg::OP_WR)
			&& ((in_ch && (ch_sel == CH_W'(n))) || in_all);
		assign ch_wr[n].sel  = wr_sel;
		assign ch_wr[n].data = data_s1;
		assign ch_active[n]  = !ch_bytes[n][pwmlc_pkg::BYTE_OFF_H][pwmlc_pkg::FLAG_FULL];

		pwmlc_chan u_chan (
			.clk        (clk),
			.arst_n     (arst_n),
			.wr         (ch_wr[n]),
			.cnt_next   (cnt_n),
			.bytes      (ch_bytes[n]),
			.level_next (lev[n])
		);
	end

	assign any_active = |ch_active;

	always_comb begin
		ptr_n   = ptr_q;
		mode1_n = mode1_q;
		mode2_n = mode2_q;
		presc_n = presc_q;
		pcnt_n  = pcnt_q;
		cnt_n   = cnt_q;
		rd_n    = '0;
		wrap_n  = 1'b0;
		rst_bit = mode1_q[pwmlc_pkg::M1_RESTART];
		ext_bit = mode1_q[pwmlc_pkg::M1_EXTCLK]
			| (mode1_q[pwmlc_pkg::M1_SLEEP] & data_s1[pwmlc_pkg::M1_EXTCLK]);
		case (op_s1)
			pwmlc_pkg::OP_PTR: begin
				ptr_n = addr_s1;
			end
			pwmlc_pkg::OP_WR: begin
				if (ptr_q == pwmlc_pkg::ADDR_MODE1) begin
					// Writing RESTART as one clears it, and restarts the counters when
					// it was set and the write wakes the block.
					if (data_s1[pwmlc_pkg::M1_RESTART]) begin
						if (mode1_q[pwmlc_pkg::M1_RESTART] && !data_s1[pwmlc_pkg::M1_SLEEP]) begin
							cnt_n  = '0;
							pcnt_n = '0;
						end
						rst_bit = 1'b0;
					end
					if (!mode1_q[pwmlc_pkg::M1_SLEEP] && data_s1[pwmlc_pkg::M1_SLEEP]
						&& any_active) begin
						rst_bit = 1'b1;
					end
					mode1_n = {rst_bit, ext_bit, data_s1[5:0]};
				end else if (ptr_q == pwmlc_pkg::ADDR_MODE2) begin
					mode2_n = data_s1 & pwmlc_pkg::HIGH_MASK;
				end else if (ptr_q == pwmlc_pkg::ADDR_PRESCALE) begin
					if (mode1_q[pwmlc_pkg::M1_SLEEP]) begin
						presc_n = (data_s1 < pwmlc_pkg::PRESCALE_MIN) ? pwmlc_pkg::PRESCALE_MIN
							: data_s1;
					end
				end
				if (mode1_n[pwmlc_pkg::M1_AUTOINC]) begin
					ptr_n = (ptr_q == ADDR_CH_LAST) ? '0 : ptr_q + 8'd1;
				end
			end
			pwmlc_pkg::OP_RD: begin
				if (ptr_q == pwmlc_pkg::ADDR_MODE1) begin
					rd_n = mode1_q;
				end else if (ptr_q == pwmlc_pkg::ADDR_MODE2) begin
					rd_n = mode2_q;
				end else if (ptr_q == pwmlc_pkg::ADDR_PRESCALE) begin
					rd_n = presc_q;
				end else if (in_ch) begin
					rd_n = ch_bytes[ch_sel][ch_off[1:0]];
				end
				if (mode1_q[pwmlc_pkg::M1_AUTOINC]) begin
					ptr_n = (ptr_q == ADDR_CH_LAST) ? '0 : ptr_q + 8'd1;
				end
			end
			pwmlc_pkg::OP_TICK: begin
				if (!mode1_q[pwmlc_pkg::M1_SLEEP]) begin
					if (pcnt_q >= presc_q) begin
						pcnt_n = '0;
						cnt_n  = cnt_q + 12'd1;
						wrap_n = (cnt_q == 12'hFFF);
					end else begin
						pcnt_n = pcnt_q + 8'd1;
					end
				end
			end
			default: begin
				ptr_n = ptr_q;
			end
		endcase
	end

	always_comb begin
		pwm_n = '0;
		for (int n = 0; n < CHANNELS; n++) begin
			pwm_n[n] = lev[n] ^ mode2_n[pwmlc_pkg::M2_INVRT];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			mode1_q <= pwmlc_pkg::MODE1_RST;
			mode2_q <= pwmlc_pkg::MODE2_RST;
			presc_q <= pwmlc_pkg::PRESCALE_RST;
			pcnt_q  <= '0;
			cnt_q   <= '0;
		end else if (proc) begin
			ptr_q   <= ptr_n;
			mode1_q <= mode1_n;
			mode2_q <= mode2_n;
			presc_q <= presc_n;
			pcnt_q  <= pcnt_n;
			cnt_q   <= cnt_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			rd_q   <= rd_n;
			pwm_q  <= pwm_n;
			wrap_q <= wrap_n;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.read_data    = rd_q;
	assign result.pwm_outputs  = pwm_q;
	assign result.period_start = wrap_q;

	// A result still waiting must not be overwritten by the next transaction.
	`ASSERT_ALWAYS(a_no_overwrite, clk, arst_n, !(out_valid_q && !result.ready && proc), "result overwritten while stalled")
	`ASSERT_ALWAYS(a_presc_min, clk, arst_n, presc_q >= pwmlc_pkg::PRESCALE_MIN, "prescale below minimum")
	`ASSERT_ALWAYS(a_wrap_zero, clk, arst_n, !(out_valid_q && wrap_q) || (cnt_q == 12'd0), "period start without zero count")
	`ASSERT_NEXT(a_sleep_hold, clk, arst_n, proc && (op_s1 == pwmlc_pkg::OP_TICK) && mode1_q[pwmlc_pkg::M1_SLEEP], $stable(cnt_q) && $stable(pcnt_q), "counter moved while asleep")
	`ASSERT_ALWAYS(a_mode2_rsvd, clk, arst_n, mode2_q[7:5] == 3'd0, "MODE2 reserved bits set")

endmodule
